[rtl/sed_pkg.sv]
// Shared types and constants of the speech endpoint detector.
`default_nettype none

package sed_pkg;

  // Field widths
  localparam int unsigned TimeW   = 16;
  localparam int unsigned WeightW = 7;
  localparam int unsigned FrameW  = 5;
  localparam int unsigned DecW    = 2;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // Frame decisions
  localparam logic [DecW-1:0] DEC_SILENCE = 2'd0;
  localparam logic [DecW-1:0] DEC_SPEECH  = 2'd1;

  // Result codes
  localparam logic [CodeW-1:0] RC_ERROR     = 3'd0;
  localparam logic [CodeW-1:0] RC_SILENCE   = 3'd1;
  localparam logic [CodeW-1:0] RC_ACTIVE    = 3'd2;
  localparam logic [CodeW-1:0] RC_BEGIN     = 3'd3;
  localparam logic [CodeW-1:0] RC_END       = 3'd4;
  localparam logic [CodeW-1:0] RC_BEGIN_END = 3'd5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BEGIN_ACTIVE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_END_SILENCE  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BEGIN_WEIGHT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_END_WEIGHT   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_MS     = 3'd4;

  // Register defaults
  localparam logic [TimeW-1:0]   DEF_BEGIN_ACTIVE = 16'd300;
  localparam logic [TimeW-1:0]   DEF_END_SILENCE  = 16'd700;
  localparam logic [WeightW-1:0] DEF_BEGIN_WEIGHT = 7'd30;
  localparam logic [WeightW-1:0] DEF_END_WEIGHT   = 7'd30;
  localparam logic [FrameW-1:0]  DEF_FRAME_MS     = 5'd10;

  // Limits
  localparam logic [WeightW-1:0] WEIGHT_MAX = 7'd100;
  localparam logic [TimeW-1:0]   TIME_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [TimeW-1:0]   begin_active_ms;
    logic [TimeW-1:0]   end_silence_ms;
    logic [WeightW-1:0] begin_weight;
    logic [WeightW-1:0] end_weight;
    logic [FrameW-1:0]  frame_ms;
  } sed_cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]   active_ms;
    logic [TimeW-1:0]   silence_ms;
    logic [WeightW-1:0] weight;
    logic               speech_on;
  } sed_state_t;

  typedef struct packed {
    logic [CodeW-1:0]   result_code;
    logic               in_speech;
    logic [WeightW-1:0] weight_now;
  } sed_result_t;

endpackage

`default_nettype wire

[rtl/sed_frame_if.sv]
// Valid/ready channels for frame decisions and detector results.
`default_nettype none

interface sed_frame_if;
  logic                          valid;
  logic                          ready;
  logic [sed_pkg::DecW-1:0]      frame_decision;

  modport source (output valid, output frame_decision, input ready);
  modport sink   (input valid, input frame_decision, output ready);
endinterface

interface sed_result_if;
  logic                          valid;
  logic                          ready;
  logic [sed_pkg::CodeW-1:0]     result_code;
  logic                          in_speech;
  logic [sed_pkg::WeightW-1:0]   weight_now;

  modport source (output valid, output result_code, output in_speech,
                  output weight_now, input ready);
  modport sink   (input valid, input result_code, input in_speech,
                  input weight_now, output ready);
endinterface

`default_nettype wire

[rtl/speech_endpoint_detector_core.sv]
// Speech endpoint detector: config registers, state, output register and skid stage.
// A result word is registered in the output register, or in the skid stage while the output is stalled.
// Throughput: one frame word per cycle while the skid stage is empty; the state update is combinational.
// A stalled result is held in the output register and one more in a skid stage;
// input ready drops only while the skid stage is full.
// Reset clears the time counters, weight and speech flag and loads register defaults.
`default_nettype none

module speech_endpoint_detector_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sed_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [sed_pkg::CfgW-1:0]       cfg_wdata_i,
  sed_frame_if.sink                           frame_i,
  sed_result_if.source                        result_o
);

  sed_pkg::sed_cfg_t    cfg_q;
  sed_pkg::sed_state_t  state_q, state_d, state_step;
  sed_pkg::sed_result_t res_step;
  sed_pkg::sed_result_t out_q, out_d, skid_q, skid_d;
  logic                 out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic                 in_acc;
  logic                 out_take;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.begin_active_ms <= sed_pkg::DEF_BEGIN_ACTIVE;
      cfg_q.end_silence_ms  <= sed_pkg::DEF_END_SILENCE;
      cfg_q.begin_weight    <= sed_pkg::DEF_BEGIN_WEIGHT;
      cfg_q.end_weight      <= sed_pkg::DEF_END_WEIGHT;
      cfg_q.frame_ms        <= sed_pkg::DEF_FRAME_MS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sed_pkg::CFG_BEGIN_ACTIVE: cfg_q.begin_active_ms <= cfg_wdata_i;
        sed_pkg::CFG_END_SILENCE:  cfg_q.end_silence_ms  <= cfg_wdata_i;
        sed_pkg::CFG_BEGIN_WEIGHT: cfg_q.begin_weight    <= cfg_wdata_i[sed_pkg::WeightW-1:0];
        sed_pkg::CFG_END_WEIGHT:   cfg_q.end_weight      <= cfg_wdata_i[sed_pkg::WeightW-1:0];
        sed_pkg::CFG_FRAME_MS:     cfg_q.frame_ms        <= cfg_wdata_i[sed_pkg::FrameW-1:0];
        default: ;
      endcase
    end
  end

  sed_step u_step (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .decision_i (frame_i.frame_decision),
    .state_o    (state_step),
    .res_o      (res_step)
  );

  // Handshake
  assign frame_i.ready = !skid_v_q;
  assign in_acc        = frame_i.valid && !skid_v_q;
  assign out_take      = out_v_q && result_o.ready;

  assign state_d = in_acc ? state_step : state_q;

  // Output register with skid stage behind it
  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (!out_v_q || out_take) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else if (in_acc) begin
        out_d   = res_step;
        out_v_d = 1'b1;
      end else begin
        out_v_d = 1'b0;
      end
    end else if (in_acc) begin
      skid_d   = res_step;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= '0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign result_o.valid       = out_v_q;
  assign result_o.result_code = out_q.result_code;
  assign result_o.in_speech   = out_q.in_speech;
  assign result_o.weight_now  = out_q.weight_now;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage full while output register empty");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && out_v_q && !result_o.ready) |=> skid_v_q)
    else $error("result lost while output stalled");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.weight <= sed_pkg::WEIGHT_MAX)
    else $error("speech weight above maximum");

  a_error_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_i.frame_decision[1]) |=> $stable(state_q))
    else $error("classifier error changed state");

  a_end_on_silence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q.speech_on) |->
      $past(in_acc && (frame_i.frame_decision == sed_pkg::DEC_SILENCE)))
    else $error("speech ended without a silence frame");

endmodule

`default_nettype wire

[rtl/sed_step.sv]
// Per-frame state update and result code of the endpoint detector.
`default_nettype none

module sed_step (
  input  sed_pkg::sed_cfg_t         cfg_i,
  input  sed_pkg::sed_state_t       state_i,
  input  logic [sed_pkg::DecW-1:0]  decision_i,
  output sed_pkg::sed_state_t       state_o,
  output sed_pkg::sed_result_t      res_o
);

  logic [sed_pkg::TimeW:0] act_sum;
  logic [sed_pkg::TimeW:0] sil_sum;
  sed_pkg::sed_state_t     upd;
  sed_pkg::sed_state_t     nxt;
  logic                    began;
  logic                    is_err;
  logic                    is_sil;
  logic [sed_pkg::CodeW-1:0] code;

  assign act_sum = {1'b0, state_i.active_ms} + {12'd0, cfg_i.frame_ms};
  assign sil_sum = {1'b0, state_i.silence_ms} + {12'd0, cfg_i.frame_ms};
  assign is_err  = decision_i[1];
  assign is_sil  = (decision_i == sed_pkg::DEC_SILENCE);

  // Counter and weight update from the frame decision
  always_comb begin
    upd = state_i;
    if (decision_i == sed_pkg::DEC_SPEECH) begin
      upd.silence_ms = '0;
      upd.active_ms  = act_sum[sed_pkg::TimeW] ? sed_pkg::TIME_MAX
                                               : act_sum[sed_pkg::TimeW-1:0];
      if (state_i.weight < sed_pkg::WEIGHT_MAX) begin
        upd.weight = state_i.weight + 7'd1;
      end
    end else if (is_sil) begin
      upd.active_ms  = '0;
      upd.silence_ms = sil_sum[sed_pkg::TimeW] ? sed_pkg::TIME_MAX
                                               : sil_sum[sed_pkg::TimeW-1:0];
      if (state_i.weight != '0) begin
        upd.weight = state_i.weight - 7'd1;
      end
    end
  end

  // Begin / end decision
  always_comb begin
    nxt   = upd;
    began = 1'b0;
    code  = sed_pkg::RC_ERROR;
    if (is_err) begin
      nxt  = state_i;
      code = sed_pkg::RC_ERROR;
    end else if (!state_i.speech_on && (upd.active_ms < cfg_i.begin_active_ms)
                 && (upd.weight < cfg_i.begin_weight)) begin
      code = sed_pkg::RC_SILENCE;
    end else begin
      // entering a segment forces full weight and clears silence time
      if (!state_i.speech_on) begin
        began          = 1'b1;
        nxt.speech_on  = 1'b1;
        nxt.weight     = sed_pkg::WEIGHT_MAX;
        nxt.silence_ms = '0;
      end
      if ((nxt.silence_ms < cfg_i.end_silence_ms) && (nxt.weight > cfg_i.end_weight)) begin
        code = began ? sed_pkg::RC_BEGIN : sed_pkg::RC_ACTIVE;
      end else if (is_sil) begin
        nxt  = '0;
        code = began ? sed_pkg::RC_BEGIN_END : sed_pkg::RC_END;
      end else begin
        code = began ? sed_pkg::RC_BEGIN : sed_pkg::RC_ACTIVE;
      end
    end
  end

  assign state_o          = nxt;
  assign res_o.result_code = code;
  assign res_o.in_speech   = nxt.speech_on;
  assign res_o.weight_now  = nxt.weight;

endmodule

`default_nettype wire

[tb/sv/tb_speech_endpoint_detector_core.sv]
// Self-checking testbench for the speech endpoint detector core.
`timescale 1ns / 1ps

module tb_speech_endpoint_detector_core;

  localparam int unsigned RunLimit = 400000;
  localparam int unsigned HoldLen  = 300;
  localparam int unsigned TailWait = 8;

  typedef logic [sed_pkg::TimeW-1:0]   time_val_t;
  typedef logic [sed_pkg::WeightW-1:0] weight_val_t;
  typedef logic [sed_pkg::FrameW-1:0]  frame_val_t;
  typedef logic [sed_pkg::DecW-1:0]    dec_val_t;
  typedef logic [sed_pkg::CfgIdxW-1:0] cfg_idx_t;
  typedef logic [sed_pkg::CfgW-1:0]    cfg_word_t;

  // Classifier error decisions (no named code in the package)
  localparam dec_val_t DEC_FAULT     = 2'd2;
  localparam dec_val_t DEC_FAULT_ALT = 2'd3;
  // Indexes past the last register
  localparam cfg_idx_t CFG_SPARE     = 3'd5;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic      cfg_we_i;
  cfg_idx_t  cfg_idx_i;
  cfg_word_t cfg_wdata_i;

  sed_frame_if  frame_if();
  sed_result_if result_if();

  speech_endpoint_detector_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_i     (frame_if),
    .result_o    (result_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state and register copy
  sed_pkg::sed_cfg_t det_cfg;
  time_val_t         det_active_ms;
  time_val_t         det_silence_ms;
  weight_val_t       det_weight;
  logic              det_speech_on;

  dec_val_t             frame_backlog[$];
  sed_pkg::sed_result_t predicted_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_ack;
  int hold_left;
  int frames_in;
  int results_checked;
  int mismatch_cnt;
  int settings_cnt;
  int cycle_cnt;
  int code_hits[6];

  // Advance the detector by one frame word and return the expected result
  function automatic sed_pkg::sed_result_t detector_step(input dec_val_t dec);
    sed_pkg::sed_result_t res;
    logic        began;
    int unsigned sum;
    began = 1'b0;
    if (dec == sed_pkg::DEC_SPEECH) begin
      det_silence_ms = '0;
      sum = det_active_ms + det_cfg.frame_ms;
      det_active_ms = (sum > sed_pkg::TIME_MAX) ? sed_pkg::TIME_MAX
                                                : sum[sed_pkg::TimeW-1:0];
      if (det_weight < sed_pkg::WEIGHT_MAX) det_weight = det_weight + 1'b1;
    end else if (dec == sed_pkg::DEC_SILENCE) begin
      sum = det_silence_ms + det_cfg.frame_ms;
      det_silence_ms = (sum > sed_pkg::TIME_MAX) ? sed_pkg::TIME_MAX
                                                 : sum[sed_pkg::TimeW-1:0];
      det_active_ms = '0;
      if (det_weight != '0) det_weight = det_weight - 1'b1;
    end

    if (dec > sed_pkg::DEC_SPEECH) begin
      res.result_code = sed_pkg::RC_ERROR;
    end else if (!det_speech_on && det_active_ms < det_cfg.begin_active_ms &&
                 det_weight < det_cfg.begin_weight) begin
      res.result_code = sed_pkg::RC_SILENCE;
    end else begin
      if (!det_speech_on) begin
        det_speech_on  = 1'b1;
        det_weight     = sed_pkg::WEIGHT_MAX;
        det_silence_ms = '0;
        began          = 1'b1;
      end
      if (det_silence_ms < det_cfg.end_silence_ms && det_weight > det_cfg.end_weight) begin
        res.result_code = began ? sed_pkg::RC_BEGIN : sed_pkg::RC_ACTIVE;
      end else if (dec == sed_pkg::DEC_SILENCE) begin
        // silence time or weight end condition met: close the segment
        det_active_ms   = '0;
        det_silence_ms  = '0;
        det_weight      = '0;
        det_speech_on   = 1'b0;
        res.result_code = began ? sed_pkg::RC_BEGIN_END : sed_pkg::RC_END;
      end else begin
        res.result_code = began ? sed_pkg::RC_BEGIN : sed_pkg::RC_ACTIVE;
      end
    end
    res.in_speech  = det_speech_on;
    res.weight_now = det_weight;
    return res;
  endfunction

  // Frame driver; predicts each word as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_if.valid          <= 1'b0;
      frame_if.frame_decision <= sed_pkg::DEC_SILENCE;
    end else begin
      if (frame_if.valid && frame_if.ready) begin
        predicted_results.push_back(detector_step(frame_if.frame_decision));
        frames_in++;
      end
      if (!frame_if.valid || frame_if.ready) begin
        if (frame_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          frame_if.valid          <= 1'b1;
          frame_if.frame_decision <= frame_backlog.pop_front();
        end else begin
          frame_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: random stalls plus a long hold-off when one is requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      hold_ack        <= 0;
      hold_left       <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack        <= hold_req;
      hold_left       <= HoldLen;
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left       <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    sed_pkg::sed_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (result_if.result_code <= sed_pkg::RC_BEGIN_END) code_hits[result_if.result_code]++;
      if (predicted_results.size() == 0) begin
        $error("unexpected result word: code %0d in_speech %0d weight %0d",
               result_if.result_code, result_if.in_speech, result_if.weight_now);
        mismatch_cnt++;
      end else begin
        want = predicted_results.pop_front();
        results_checked++;
        if (result_if.result_code !== want.result_code) begin
          $error("result_code: expected %0d, got %0d", want.result_code,
                 result_if.result_code);
          mismatch_cnt++;
        end
        if (result_if.in_speech !== want.in_speech) begin
          $error("in_speech: expected %0d, got %0d", want.in_speech, result_if.in_speech);
          mismatch_cnt++;
        end
        if (result_if.weight_now !== want.weight_now) begin
          $error("weight_now: expected %0d, got %0d", want.weight_now,
                 result_if.weight_now);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= RunLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input cfg_word_t data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      sed_pkg::CFG_BEGIN_ACTIVE: det_cfg.begin_active_ms = data;
      sed_pkg::CFG_END_SILENCE:  det_cfg.end_silence_ms  = data;
      sed_pkg::CFG_BEGIN_WEIGHT: det_cfg.begin_weight    = data[sed_pkg::WeightW-1:0];
      sed_pkg::CFG_END_WEIGHT:   det_cfg.end_weight      = data[sed_pkg::WeightW-1:0];
      sed_pkg::CFG_FRAME_MS:     det_cfg.frame_ms        = data[sed_pkg::FrameW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Narrow registers get random junk above their width
  task automatic set_config(input time_val_t ba, input time_val_t es,
                            input weight_val_t bw, input weight_val_t ew,
                            input frame_val_t fm);
    cfg_word_t word;
    write_reg(sed_pkg::CFG_BEGIN_ACTIVE, ba);
    write_reg(sed_pkg::CFG_END_SILENCE, es);
    word = cfg_word_t'($urandom);
    word[sed_pkg::WeightW-1:0] = bw;
    write_reg(sed_pkg::CFG_BEGIN_WEIGHT, word);
    word = cfg_word_t'($urandom);
    word[sed_pkg::WeightW-1:0] = ew;
    write_reg(sed_pkg::CFG_END_WEIGHT, word);
    word = cfg_word_t'($urandom);
    word[sed_pkg::FrameW-1:0] = fm;
    write_reg(sed_pkg::CFG_FRAME_MS, word);
    settings_cnt++;
  endtask

  function automatic time_val_t pick_time(input int unsigned span);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return time_val_t'($urandom_range(0, span));
    if (roll < 85) return time_val_t'($urandom);
    return $urandom_range(1) ? sed_pkg::TIME_MAX : '0;
  endfunction

  task automatic random_config();
    weight_val_t bw;
    weight_val_t ew;
    frame_val_t  fm;
    if ($urandom_range(99) < 80) fm = frame_val_t'(10 * $urandom_range(1, 3));
    else fm = frame_val_t'($urandom_range(0, 31));
    bw = weight_val_t'(($urandom_range(99) < 85) ? $urandom_range(0, 100)
                                                 : $urandom_range(101, 127));
    ew = weight_val_t'(($urandom_range(99) < 85) ? $urandom_range(0, 100)
                                                 : $urandom_range(101, 127));
    set_config(pick_time(600), pick_time(900), bw, ew, fm);
  endtask

  // Mostly runs of speech or silence, with short error bursts and some noise
  task automatic queue_runs(input int n);
    int left;
    int len;
    int pick;
    dec_val_t dec;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(99);
      len  = (pick < 8) ? $urandom_range(1, 3) : $urandom_range(1, 40);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        if (pick < 8) dec = $urandom_range(1) ? DEC_FAULT : DEC_FAULT_ALT;
        else if (pick < 52) dec = sed_pkg::DEC_SPEECH;
        else dec = sed_pkg::DEC_SILENCE;
        if (pick >= 8 && $urandom_range(99) < 5) dec = dec_val_t'($urandom_range(0, 3));
        frame_backlog.push_back(dec);
      end
      left -= len;
    end
  endtask

  // Wait until the backlog is sent and every predicted word has come back
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (frame_backlog.size() != 0 || frame_if.valid || predicted_results.size() != 0);
  endtask

  initial begin
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= sed_pkg::CFG_BEGIN_ACTIVE;
    cfg_wdata_i    <= '0;
    rst_ni         <= 1'b0;
    send_idle_pct  = 18;
    recv_idle_pct  = 80;
    hold_req       = 0;
    frames_in      = 0;
    results_checked = 0;
    mismatch_cnt   = 0;
    settings_cnt   = 0;
    cycle_cnt      = 0;
    foreach (code_hits[i]) code_hits[i] = 0;
    det_cfg        = '{sed_pkg::DEF_BEGIN_ACTIVE, sed_pkg::DEF_END_SILENCE,
                       sed_pkg::DEF_BEGIN_WEIGHT, sed_pkg::DEF_END_WEIGHT,
                       sed_pkg::DEF_FRAME_MS};
    det_active_ms  = '0;
    det_silence_ms = '0;
    det_weight     = '0;
    det_speech_on  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    #1;

    // Defaults: error decisions of both kinds, speech before begin
    frame_backlog = '{DEC_FAULT, DEC_FAULT_ALT, sed_pkg::DEC_SILENCE, sed_pkg::DEC_SPEECH};
    wait_idle();

    // Begin on active time, end on silence time, error while idle
    set_config(16'd20, 16'd30, 7'd100, 7'd0, 5'd10);
    frame_backlog = '{sed_pkg::DEC_SPEECH, sed_pkg::DEC_SPEECH, sed_pkg::DEC_SPEECH,
                      sed_pkg::DEC_SILENCE, sed_pkg::DEC_SILENCE, sed_pkg::DEC_SILENCE,
                      DEC_FAULT};
    wait_idle();

    // End on weight floor
    write_reg(sed_pkg::CFG_END_WEIGHT, 16'd100);
    frame_backlog = '{sed_pkg::DEC_SPEECH, sed_pkg::DEC_SPEECH, sed_pkg::DEC_SILENCE};
    wait_idle();

    // Begin and end on one silence frame, then begin on speech
    write_reg(sed_pkg::CFG_BEGIN_ACTIVE, 16'd0);
    write_reg(sed_pkg::CFG_END_SILENCE, 16'd0);
    frame_backlog = '{sed_pkg::DEC_SILENCE, sed_pkg::DEC_SPEECH, sed_pkg::DEC_SPEECH};
    wait_idle();

    // Spare indexes must leave the registers alone
    for (int i = 0; i < 3; i++) write_reg(cfg_idx_t'(CFG_SPARE + i), cfg_word_t'($urandom));

    // Random phases under three idling regimes
    for (int p = 0; p < 12; p++) begin
      wait_idle();
      if (p == 0) set_config(sed_pkg::TIME_MAX, sed_pkg::TIME_MAX, 7'd127, 7'd127, 5'd31);
      else if (p == 1) set_config('0, '0, '0, '0, '0);
      else if (p == 2) set_config(sed_pkg::DEF_BEGIN_ACTIVE, sed_pkg::DEF_END_SILENCE,
                                  sed_pkg::DEF_BEGIN_WEIGHT, sed_pkg::DEF_END_WEIGHT,
                                  sed_pkg::DEF_FRAME_MS);
      else random_config();
      if (p < 4) begin
        send_idle_pct = 18;
        recv_idle_pct = 80;
      end else if (p < 8) begin
        send_idle_pct = 80;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 9) hold_req++;
      queue_runs(160);
    end

    wait_idle();
    repeat (TailWait) @(posedge clk_i);
    $display("Run covered %0d frame words over %0d register settings, %0d results checked.",
             frames_in, settings_cnt, results_checked);
    $display("Codes seen: %0d error, %0d silence, %0d active, %0d begin, %0d end, %0d both.",
             code_hits[0], code_hits[1], code_hits[2], code_hits[3], code_hits[4],
             code_hits[5]);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
